@@ rtl/great_circle_distance_defines.svh @@
// assertion macros for the rtl
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// same-cycle implication
`define GCD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define GCD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/gcd_pkg.sv @@
package gcd_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic signed [30:0] DEG_FULL    = 31'sd754974720;
  localparam logic signed [30:0] DEG_HALF    = 31'sd377487360;
  localparam logic signed [30:0] DEG_QUARTER = 31'sd188743680;
  localparam logic [27:0] RAD_PER_UNIT = 28'd149922641;
  localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
  localparam logic signed [33:0] Q_ONE = 34'sd1073741824;
  localparam logic [30:0] HALF_PI_Q = 31'd1686629713;
  localparam logic [24:0] DIST_MAX = 25'd31415927;
  localparam logic [23:0] RADIUS_RESET = 24'd6371000;

  localparam logic [30:0] ATAN_TAB [32] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
    31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
    31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
    31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
  };

  // q30 product, rounded
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 32'(p >>> 30);
  endfunction

endpackage

@@ rtl/gcd_if.sv @@
interface gcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [27:0] lat_a;
  logic signed [28:0] lon_a;
  logic signed [27:0] lat_b;
  logic signed [28:0] lon_b;

  modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] distance_m;

  modport source (output valid, distance_m, input ready);
  modport sink (input valid, distance_m, output ready);
endinterface

@@ rtl/great_circle_distance.sv @@
// channel  dir  beat
// pts      in   lat_a, lon_a, lat_b, lon_b (degrees * 2^20)
// result   out  distance_m (meters)
// cfg      in   cfg_write_en / cfg_write_data: earth_radius_m
//
// one pair per cycle while result is not stalled; the depth is set by the two
// unrolled cordic chains and the 32-stage square root
// rst is synchronous; it empties the pipeline and loads the radius reset value
// a stalled result beat freezes the whole pipeline; one more pts beat lands in
// an input skid register, so pts.ready is low only while that register is full
`include "great_circle_distance_defines.svh"

module great_circle_distance #(
  parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  gcd_in_if.sink      pts,
  gcd_out_if.source   result,
  input  logic        cfg_write_en,
  input  logic [23:0] cfg_write_data
);

  logic [23:0] earth_radius_m;
  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius_m <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_write_en) begin
      earth_radius_m <= cfg_write_data;
    end
  end

  logic en;
  logic fire;
  assign en   = !result.valid || result.ready;
  assign fire = pts.valid && pts.ready;

  // input skid
  logic               skid_valid;
  logic signed [27:0] sk_lat_a, sk_lat_b;
  logic signed [28:0] sk_lon_a, sk_lon_b;
  assign pts.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && fire) begin
      sk_lat_a <= pts.lat_a;
      sk_lon_a <= pts.lon_a;
      sk_lat_b <= pts.lat_b;
      sk_lon_b <= pts.lon_b;
    end
  end

  logic signed [27:0] f_lat_a, f_lat_b;
  logic signed [28:0] f_lon_a, f_lon_b;
  logic               f_valid;
  assign f_valid = skid_valid || fire;
  assign f_lat_a = skid_valid ? sk_lat_a : pts.lat_a;
  assign f_lon_a = skid_valid ? sk_lon_a : pts.lon_a;
  assign f_lat_b = skid_valid ? sk_lat_b : pts.lat_b;
  assign f_lon_b = skid_valid ? sk_lon_b : pts.lon_b;

  // angle differences and doubled latitudes, units of 2^-21 degree
  logic               e_valid;
  logic signed [29:0] t_dlat, t_dlon, t_lat1, t_lat2;
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= f_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t_dlat <= 30'(f_lat_b) - 30'(f_lat_a);
      t_dlon <= 30'(f_lon_b) - 30'(f_lon_a);
      t_lat1 <= 30'(f_lat_a) <<< 1;
      t_lat2 <= 30'(f_lat_b) <<< 1;
    end
  end

  logic               sc_valid, sc_v1, sc_v2, sc_v3;
  logic signed [31:0] s_lat, s_lon, c1, c2;
  logic signed [31:0] cs_dlat, cs_dlon, sn_lat1, sn_lat2;

  gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlat (
    .clk, .rst, .en, .in_valid(e_valid), .t(t_dlat),
    .out_valid(sc_valid), .sn(s_lat), .cs(cs_dlat)
  );
  gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlon (
    .clk, .rst, .en, .in_valid(e_valid), .t(t_dlon),
    .out_valid(sc_v1), .sn(s_lon), .cs(cs_dlon)
  );
  gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat1 (
    .clk, .rst, .en, .in_valid(e_valid), .t(t_lat1),
    .out_valid(sc_v2), .sn(sn_lat1), .cs(c1)
  );
  gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat2 (
    .clk, .rst, .en, .in_valid(e_valid), .t(t_lat2),
    .out_valid(sc_v3), .sn(sn_lat2), .cs(c2)
  );

  // haversine sum
  logic               m1_valid, m2_valid, m3_valid;
  logic signed [31:0] p_lat, p_cc, p_lon, m2_lat, m2_q;
  logic [30:0]        hx, hx_inv;
  logic signed [32:0] hsum;
  logic [30:0]        hx_next;

  assign hsum = 33'(m2_lat) + 33'(m2_q);
  always_comb begin
    if (hsum < 0) begin
      hx_next = '0;
    end else if (hsum > 33'(gcd_pkg::Q_ONE)) begin
      hx_next = 31'(gcd_pkg::Q_ONE);
    end else begin
      hx_next = 31'(hsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= sc_valid && sc_v1 && sc_v2 && sc_v3;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lat  <= gcd_pkg::mulq(s_lat, s_lat);
      p_cc   <= gcd_pkg::mulq(c1, c2);
      p_lon  <= gcd_pkg::mulq(s_lon, s_lon);
      m2_lat <= p_lat;
      m2_q   <= gcd_pkg::mulq(p_cc, p_lon);
      hx     <= hx_next;
      hx_inv <= 31'(gcd_pkg::Q_ONE) - hx_next;
    end
  end

  logic        rt_valid, rt_v1;
  logic [30:0] root_x, root_1x;

  gcd_sqrt u_sqrt_x (
    .clk, .rst, .en, .in_valid(m3_valid), .v({hx, 30'd0}),
    .out_valid(rt_valid), .root(root_x)
  );
  gcd_sqrt u_sqrt_1x (
    .clk, .rst, .en, .in_valid(m3_valid), .v({hx_inv, 30'd0}),
    .out_valid(rt_v1), .root(root_1x)
  );

  logic        at_valid;
  logic [30:0] angle;

  gcd_atan2 #(.STEPS(CORDIC_STEPS)) u_atan2 (
    .clk, .rst, .en, .in_valid(rt_valid && rt_v1), .ya(root_x), .xb(root_1x),
    .out_valid(at_valid), .angle(angle)
  );

  // scale by the radius; angle is half the central angle
  logic        d1_valid;
  logic [54:0] dprod;
  logic [25:0] dround;
  assign dround = 26'((dprod + 55'd268435456) >> 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      d1_valid     <= at_valid;
      result.valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dprod <= 55'(earth_radius_m) * 55'(angle);
      result.distance_m <= (dround > 26'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
                                                             : 25'(dround);
    end
  end

  `GCD_ASSERT_NOW(a_dist_sat, result.valid, result.distance_m <= gcd_pkg::DIST_MAX)
  `GCD_ASSERT_NEXT(a_skid_load, fire && !en, skid_valid)
  `GCD_ASSERT_NEXT(a_radius_wr, cfg_write_en, earth_radius_m == $past(cfg_write_data))
  `GCD_ASSERT_NEXT(a_skid_hold, skid_valid && !en, skid_valid)

endmodule

@@ rtl/gcd_sincos.sv @@
module gcd_sincos #(
  parameter int STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [29:0] t,
  output logic               out_valid,
  output logic signed [31:0] sn,
  output logic signed [31:0] cs
);

  logic signed [30:0] w;
  logic signed [30:0] u_next;
  logic               neg_cos_next;

  // wrap to a half turn, then fold into [-90, 90] degrees
  always_comb begin
    if (31'(t) > gcd_pkg::DEG_HALF) begin
      w = 31'(t) - gcd_pkg::DEG_FULL;
    end else if (31'(t) < -gcd_pkg::DEG_HALF) begin
      w = 31'(t) + gcd_pkg::DEG_FULL;
    end else begin
      w = 31'(t);
    end
    if (w > gcd_pkg::DEG_QUARTER) begin
      u_next = gcd_pkg::DEG_HALF - w;
      neg_cos_next = 1'b1;
    end else if (w < -gcd_pkg::DEG_QUARTER) begin
      u_next = -gcd_pkg::DEG_HALF - w;
      neg_cos_next = 1'b1;
    end else begin
      u_next = w;
      neg_cos_next = 1'b0;
    end
  end

  logic               va, vb, vc_unused;
  logic signed [28:0] u;
  logic               nca, ncb;
  logic [55:0]        mag;
  logic               negb;

  logic               cv [STEPS+1];
  logic signed [33:0] cx [STEPS+1];
  logic signed [33:0] cy [STEPS+1];
  logic signed [33:0] cz [STEPS+1];
  logic               cn [STEPS+1];

  logic [27:0] umag;
  logic [31:0] rad;
  assign umag = u[28] ? 28'(-u) : 28'(u);
  assign rad  = 32'((mag + 56'd8388608) >> 24);
  assign vc_unused = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      cv[0] <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      cv[0] <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u    <= 29'(u_next);
      nca  <= neg_cos_next;
      mag  <= 56'(umag) * 56'(gcd_pkg::RAD_PER_UNIT);
      negb <= u[28];
      ncb  <= nca;
      cx[0] <= gcd_pkg::GAIN_INV;
      cy[0] <= '0;
      cz[0] <= negb ? -34'(rad) : 34'(rad);
      cn[0] <= ncb;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_rot
    localparam logic signed [33:0] AT = 34'(gcd_pkg::ATAN_TAB[k % 32]);
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else if (en) begin
        cv[k+1] <= cv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cn[k+1] <= cn[k];
        if (cz[k] >= 0) begin
          cx[k+1] <= cx[k] - (cy[k] >>> k);
          cy[k+1] <= cy[k] + (cx[k] >>> k);
          cz[k+1] <= cz[k] - AT;
        end else begin
          cx[k+1] <= cx[k] + (cy[k] >>> k);
          cy[k+1] <= cy[k] - (cx[k] >>> k);
          cz[k+1] <= cz[k] + AT;
        end
      end
    end
  end

  logic signed [33:0] xc, yc;
  always_comb begin
    xc = cx[STEPS];
    if (xc > gcd_pkg::Q_ONE) xc = gcd_pkg::Q_ONE;
    if (xc < -gcd_pkg::Q_ONE) xc = -gcd_pkg::Q_ONE;
    yc = cy[STEPS];
    if (yc > gcd_pkg::Q_ONE) yc = gcd_pkg::Q_ONE;
    if (yc < -gcd_pkg::Q_ONE) yc = -gcd_pkg::Q_ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[STEPS] | vc_unused;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn <= 32'(yc);
      cs <= cn[STEPS] ? 32'(-xc) : 32'(xc);
    end
  end

endmodule

@@ rtl/gcd_sqrt.sv @@
module gcd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [60:0] v,
  output logic        out_valid,
  output logic [30:0] root
);

  localparam int ITER = 32;

  logic        sv  [ITER+1];
  logic [63:0] rem [ITER+1];
  logic [63:0] res [ITER+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= 64'(v);
      res[0] <= '0;
    end
  end

  // one result bit per stage
  for (genvar k = 0; k < ITER; k++) begin : g_bit
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign out_valid = sv[ITER];
  assign root      = res[ITER][30:0];

endmodule

@@ rtl/gcd_atan2.sv @@
module gcd_atan2 #(
  parameter int STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [30:0] ya,
  input  logic [30:0] xb,
  output logic        out_valid,
  output logic [30:0] angle
);

  logic               av [STEPS+1];
  logic signed [33:0] ax [STEPS+1];
  logic signed [33:0] ay [STEPS+1];
  logic signed [33:0] az [STEPS+1];
  logic               zf [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      av[0] <= 1'b0;
    end else if (en) begin
      av[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax[0] <= 34'(xb);
      ay[0] <= 34'(ya);
      az[0] <= '0;
      zf[0] <= (xb == '0) && (ya == '0);
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_vec
    localparam logic signed [33:0] AT = 34'(gcd_pkg::ATAN_TAB[k % 32]);
    always_ff @(posedge clk) begin
      if (rst) begin
        av[k+1] <= 1'b0;
      end else if (en) begin
        av[k+1] <= av[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zf[k+1] <= zf[k];
        if (ay[k] >= 0) begin
          ax[k+1] <= ax[k] + (ay[k] >>> k);
          ay[k+1] <= ay[k] - (ax[k] >>> k);
          az[k+1] <= az[k] + AT;
        end else begin
          ax[k+1] <= ax[k] - (ay[k] >>> k);
          ay[k+1] <= ay[k] + (ax[k] >>> k);
          az[k+1] <= az[k] - AT;
        end
      end
    end
  end

  logic [30:0] zc;
  always_comb begin
    if (zf[STEPS] || az[STEPS] < 0) begin
      zc = '0;
    end else if (az[STEPS] > 34'(gcd_pkg::HALF_PI_Q)) begin
      zc = gcd_pkg::HALF_PI_Q;
    end else begin
      zc = 31'(az[STEPS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= av[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zc;
    end
  end

endmodule
